FILE: hw/rtl/dnym_pkg.sv
// Shared types, constants and calendar helpers for the day-number-to-month block.
`timescale 1ns / 1ps

package dnym_pkg;

  // Signed width for day numbers and month-start values over all legal spans.
  localparam int DAY_W = 20;
  localparam int IN_W = 17;
  localparam int YEAR_W = 12;
  localparam int MONTH_W = 4;
  localparam int MIDX_W = 11;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [MONTH_W-1:0] MONTH_JAN = 4'd0;
  localparam logic [MONTH_W-1:0] MONTH_MAR = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC = 4'd11;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_YEAR,
    ST_MONTH,
    ST_FINISH
  } state_e;

  typedef struct packed {
    logic load;
    logic year_step;
    logic month_init;
    logic month_step;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic range_miss;
    logic year_done;
    logic month_done;
  } sts_t;

  // Day number of y-m-d counted from 1970-01-01; used at elaboration only.
  function automatic int days_from_civil(int y, int m, int d);
    int yy;
    int era;
    int yoe;
    int mp;
    int doy;
    int doe;
    yy  = (m <= 2) ? (y - 1) : y;
    era = yy / 400;
    yoe = yy - era * 400;
    mp  = (m > 2) ? (m - 3) : (m + 9);
    doy = (153 * mp + 2) / 5 + d - 1;
    doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
    return era * 146097 + doe - 719468;
  endfunction

  function automatic logic is_leap(int y);
    return ((y % 4) == 0) && (((y % 100) != 0) || ((y % 400) == 0));
  endfunction

  // Days from January 1 to the first of month m (0 = January), common year.
  function automatic logic [8:0] month_offset(logic [MONTH_W-1:0] m);
    logic [8:0] off;
    case (m)
      4'd0:    off = 9'd0;
      4'd1:    off = 9'd31;
      4'd2:    off = 9'd59;
      4'd3:    off = 9'd90;
      4'd4:    off = 9'd120;
      4'd5:    off = 9'd151;
      4'd6:    off = 9'd181;
      4'd7:    off = 9'd212;
      4'd8:    off = 9'd243;
      4'd9:    off = 9'd273;
      4'd10:   off = 9'd304;
      4'd11:   off = 9'd334;
      default: off = 9'd0;
    endcase
    return off;
  endfunction

endpackage

FILE: hw/rtl/day_number_to_year_month.sv
// Top level: day number since 1970-01-01 to Gregorian year, month and month index.
`timescale 1ns / 1ps

// Channel   Dir  Handshake          Payload (low bit up)
// s_axis    in   tvalid/tready      tdata: day_number[16:0], zero pad [23:17]
// m_axis    out  tvalid/tready      tdata: calendar_year[11:0], calendar_month[15:12],
//                                   month_index[26:16], zero pad [31:27]
//                                   tuser: out_of_range[0]
//
// One word at a time: an accept step, the binary search over year starts
// (log2 YEAR_SPAN probes, 7 at the default span), a step to latch the year
// base, 3 or 4 month probes, a step to see the month search settle, and a
// result step.
// The year-start table is the search loop's probe.
// Out-of-range days skip both searches.
// Reset clears the sequencer and the output valid only.
// The result sits in an output register; a new word is taken while it waits,
// and the sequencer only holds in its last step if the register is still full.

module day_number_to_year_month #(
  parameter int FIRST_YEAR = 1948,
  parameter int YEAR_SPAN  = 128
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid_i,
  output logic                                s_axis_tready_o,
  input  logic [dnym_pkg::IN_TDATA_W-1:0]     s_axis_tdata_i,   // day_number
  output logic                                m_axis_tvalid_o,
  input  logic                                m_axis_tready_i,
  output logic [dnym_pkg::OUT_TDATA_W-1:0]    m_axis_tdata_o,   // year, month, month_index
  output logic [0:0]                          m_axis_tuser_o    // out_of_range
);
  import dnym_pkg::*;

  localparam logic [MIDX_W-1:0] LastIdx = MIDX_W'(12 * YEAR_SPAN - 1);

  cmd_t               cmd;
  sts_t               sts;
  logic [YEAR_W-1:0]  cal_year;
  logic [MONTH_W-1:0] cal_month;
  logic [MIDX_W-1:0]  month_idx;
  logic               oor;

  dnym_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_ready_o  (s_axis_tready_o),
    .out_valid_o (m_axis_tvalid_o),
    .out_ready_i (m_axis_tready_i),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dnym_datapath #(
    .FIRST_YEAR (FIRST_YEAR),
    .YEAR_SPAN  (YEAR_SPAN)
  ) u_datapath (
    .clk_i            (clk_i),
    .day_number_i     ($signed(s_axis_tdata_i[IN_W-1:0])),
    .cmd_i            (cmd),
    .sts_o            (sts),
    .calendar_year_o  (cal_year),
    .calendar_month_o (cal_month),
    .month_index_o    (month_idx),
    .out_of_range_o   (oor)
  );

  // Pack result fields from the low bit up, pad to whole bytes.
  assign m_axis_tdata_o = OUT_TDATA_W'({month_idx, cal_month, cal_year});
  assign m_axis_tuser_o = oor;

  // A taken word leaves the sequencer busy on the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input taken twice without a search in between");

  // Month of year stays in 1..12 whenever a result is shown.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (cal_month >= 4'd1) && (cal_month <= 4'd12))
    else $error("month out of 1..12");

  // A saturated result is the first or the last month.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && oor |-> (month_idx == '0) || (month_idx == LastIdx))
    else $error("out-of-range result not saturated");

endmodule

FILE: hw/rtl/dnym_ctrl.sv
// Sequencer for the year search, month search and result hand-off.
`timescale 1ns / 1ps

module dnym_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  dnym_pkg::sts_t sts_i,
  output dnym_pkg::cmd_t cmd_o
);
  import dnym_pkg::*;

  state_e state_q, state_d;
  logic   out_valid_q, out_valid_d;
  logic   out_free;

  assign out_free = !out_valid_q || out_ready_i;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) state_d = ST_YEAR;
      end
      ST_YEAR: begin
        if (sts_i.range_miss) state_d = ST_FINISH;
        else if (sts_i.year_done) state_d = ST_MONTH;
      end
      ST_MONTH: begin
        if (sts_i.month_done) state_d = ST_FINISH;
      end
      ST_FINISH: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o  = 1'b1;
        cmd_o.load  = in_valid_i;
      end
      ST_YEAR: begin
        if (!sts_i.range_miss) begin
          cmd_o.month_init = sts_i.year_done;
          cmd_o.year_step  = !sts_i.year_done;
        end
      end
      ST_MONTH: begin
        cmd_o.month_step = !sts_i.month_done;
      end
      ST_FINISH: begin
        cmd_o.finish = out_free;
      end
      default: ;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_ready_i) out_valid_d = 1'b0;
    if (cmd_o.finish) out_valid_d = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

FILE: hw/rtl/dnym_datapath.sv
// Year-start table, search registers, probe compares and result registers.
`timescale 1ns / 1ps

module dnym_datapath #(
  parameter int FIRST_YEAR = 1948,
  parameter int YEAR_SPAN  = 128
) (
  input  logic                                clk_i,
  input  logic signed [dnym_pkg::IN_W-1:0]    day_number_i,
  input  dnym_pkg::cmd_t                      cmd_i,
  output dnym_pkg::sts_t                      sts_o,
  output logic [dnym_pkg::YEAR_W-1:0]         calendar_year_o,
  output logic [dnym_pkg::MONTH_W-1:0]        calendar_month_o,
  output logic [dnym_pkg::MIDX_W-1:0]         month_index_o,
  output logic                                out_of_range_o
);
  import dnym_pkg::*;

  localparam int YW    = (YEAR_SPAN > 1) ? $clog2(YEAR_SPAN) : 1;
  localparam int IDX_W = $clog2(12 * YEAR_SPAN);

  typedef logic [YEAR_SPAN-1:0][DAY_W-1:0] ystart_t;

  function automatic ystart_t build_ystart();
    ystart_t t;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      t[i] = DAY_W'(days_from_civil(FIRST_YEAR + i, 1, 1));
    end
    return t;
  endfunction

  function automatic logic [YEAR_SPAN-1:0] build_leap();
    logic [YEAR_SPAN-1:0] t;
    for (int i = 0; i < YEAR_SPAN; i++) begin
      t[i] = is_leap(FIRST_YEAR + i);
    end
    return t;
  endfunction

  localparam ystart_t              YStart  = build_ystart();
  localparam logic [YEAR_SPAN-1:0] YLeap   = build_leap();
  localparam logic [DAY_W-1:0]     SpanEnd =
    DAY_W'(days_from_civil(FIRST_YEAR + YEAR_SPAN, 1, 1));
  localparam logic [YW-1:0]        YLast   = YW'(YEAR_SPAN - 1);

  logic signed [DAY_W-1:0] x_q;
  logic                    below_q, above_q;
  logic [YW-1:0]           ylo_q, yhi_q;
  logic [MONTH_W-1:0]      mlo_q, mhi_q;
  logic [DAY_W-1:0]        base_q;
  logic                    leap_q;

  logic signed [DAY_W-1:0] x_ext;
  logic [YW-1:0]           ymid;
  logic [MONTH_W-1:0]      mmid;
  logic signed [DAY_W-1:0] ystart_mid;
  logic signed [DAY_W-1:0] mstart_mid;
  logic                    ytake, mtake;
  logic [YW-1:0]           yres;
  logic [MONTH_W-1:0]      mres;
  logic [IDX_W-1:0]        idx_full;

  assign x_ext = DAY_W'(day_number_i);

  // Upper-middle probe so that lo always moves or hi shrinks.
  assign ymid = YW'(({1'b0, ylo_q} + {1'b0, yhi_q} + (YW+1)'(1)) >> 1);
  assign mmid = MONTH_W'(({1'b0, mlo_q} + {1'b0, mhi_q} + 5'd1) >> 1);

  assign ystart_mid = $signed(YStart[ymid]);
  assign mstart_mid = $signed(base_q) + $signed(DAY_W'(month_offset(mmid)))
                    + $signed(DAY_W'(leap_q && (mmid >= MONTH_MAR)));

  assign ytake = ystart_mid <= x_q;
  assign mtake = mstart_mid <= x_q;

  assign sts_o.range_miss = below_q || above_q;
  assign sts_o.year_done  = ylo_q == yhi_q;
  assign sts_o.month_done = mlo_q == mhi_q;

  always_comb begin
    if (below_q) begin
      yres = '0;
      mres = MONTH_JAN;
    end else if (above_q) begin
      yres = YLast;
      mres = MONTH_DEC;
    end else begin
      yres = ylo_q;
      mres = mlo_q;
    end
    idx_full = IDX_W'({yres, 3'b000}) + IDX_W'({yres, 2'b00}) + IDX_W'(mres);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      x_q     <= x_ext;
      below_q <= x_ext < $signed(YStart[0]);
      above_q <= x_ext >= $signed(SpanEnd);
      ylo_q   <= '0;
      yhi_q   <= YLast;
    end
    if (cmd_i.year_step) begin
      if (ytake) ylo_q <= ymid;
      else       yhi_q <= ymid - YW'(1);
    end
    if (cmd_i.month_init) begin
      base_q <= YStart[ylo_q];
      leap_q <= YLeap[ylo_q];
      mlo_q  <= MONTH_JAN;
      mhi_q  <= MONTH_DEC;
    end
    if (cmd_i.month_step) begin
      if (mtake) mlo_q <= mmid;
      else       mhi_q <= mmid - 4'd1;
    end
    if (cmd_i.finish) begin
      calendar_year_o  <= YEAR_W'(FIRST_YEAR) + YEAR_W'(yres);
      calendar_month_o <= mres + 4'd1;
      month_index_o    <= MIDX_W'(idx_full);
      out_of_range_o   <= below_q || above_q;
    end
  end

endmodule
